### rtl/sorted_unique_count_gap_assert.svh
// assertion macros for the sorted distinct-value histogram
// no dependencies; included by the top level
`ifndef SORTED_UNIQUE_COUNT_GAP_ASSERT_SVH
`define SORTED_UNIQUE_COUNT_GAP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SUCG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sucg check failed");

// next-cycle implication, checked out of reset
`define SUCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sucg check failed");

`endif

### rtl/sucg_pkg.sv
// shared types and constants for the sorted distinct-value histogram
// no dependencies
package sucg_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_START = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      last_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] distinct_value;
        logic [COUNT_W-1:0]        occurrence_count;
        logic [VALUE_W-1:0]        gap_halves;
        logic                      last_result;
        logic                      overflow_flag;
    } t_out_word;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } t_cell_data;

    // what a cell hands to its right-hand neighbor
    typedef struct packed {
        t_cell_data data;
        logic       less;
    } t_link;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ABSORB,
        CELL_SHIFT
    } t_cell_op;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

### rtl/sorted_unique_count_gap.sv
// top level of the sorted distinct-value histogram with neighbor gaps
// depends on sucg_pkg, sucg_cell and sorted_unique_count_gap_assert.svh
//
//   channel | valid       | stall       | word
//   --------+-------------+-------------+------------------------
//   input   | i_in_valid  | o_in_stall  | i_in_data  (t_in_word)
//   output  | o_out_valid | i_out_stall | o_out_data (t_out_word)
//
// loading takes one word per cycle: every cell compares against the sample at once
// and the row shifts right by one cell behind the insertion point
// after the last word the row drains from cell 0, one result per cycle while the output
// does not stall; the input stalls until the drain is done
// reset is synchronous, active low; it empties the row, no clearing pass
// an output stall freezes the drain; the next axis may load while the last result waits
`include "sorted_unique_count_gap_assert.svh"

module sorted_unique_count_gap import sucg_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    // chain of cells
    t_link                     w_cell  [MAX_POINTS];
    t_link                     w_left  [MAX_POINTS];
    t_cell_data                w_right [MAX_POINTS];
    logic [MAX_POINTS-1:0]     w_match;
    t_cell_op                  w_op;
    logic                      w_any_match;
    logic                      w_full;
    logic                      w_insert;

    // sequencing and output registers
    t_state                    r_state, n_state;
    logic                      r_drop, n_drop;
    logic signed [VALUE_W-1:0] r_prev;
    logic                      r_prev_valid, n_prev_valid;
    logic                      r_out_valid, n_out_valid;
    t_out_word                 r_out_data, n_out_data;

    logic                      w_in_accept;
    logic                      w_emit_adv;
    t_cell_data                w_head;
    t_cell_data                w_next;
    logic [VALUE_W-1:0]        w_hi;
    logic [VALUE_W-1:0]        w_lo;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_any_match = |w_match;
    // the row is full once the rightmost cell holds a value
    assign w_full      = w_cell[MAX_POINTS-1].data.valid;
    assign w_insert    = !w_any_match && !w_full;

    genvar g;
    generate
        for (g = 0; g < MAX_POINTS; g++) begin : g_cell
            if (g == 0) begin : g_head
                // left of cell 0 counts as smaller than anything
                assign w_left[g] = '{data: '0, less: 1'b1};
            end else begin : g_body
                assign w_left[g] = w_cell[g-1];
            end
            if (g == MAX_POINTS - 1) begin : g_tail
                assign w_right[g] = '0;
            end else begin : g_inner
                assign w_right[g] = w_cell[g+1].data;
            end

            sucg_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_op     (w_op),
                .i_sample (i_in_data.sample_value),
                .i_insert (w_insert),
                .i_left   (w_left[g]),
                .i_right  (w_right[g]),
                .o_link   (w_cell[g]),
                .o_match  (w_match[g])
            );
        end
    endgenerate

    // result at the head of the row
    assign w_head = w_cell[0].data;
    assign w_next = w_cell[1].data;
    // upper neighbor, or itself on the last value
    assign w_hi   = w_next.valid ? w_next.value : w_head.value;
    // lower neighbor, or itself on the first value
    assign w_lo   = r_prev_valid ? r_prev : w_head.value;

    // drain moves whenever the output register is free or being taken
    assign w_emit_adv = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state      = r_state;
        n_drop       = r_drop;
        n_prev_valid = r_prev_valid;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        w_op         = CELL_HOLD;
        o_in_stall   = 1'b1;
        unique case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (w_in_accept) begin
                    w_op = CELL_ABSORB;
                    // unseen value with no room left: dropped
                    if (!w_any_match && w_full) begin
                        n_drop = 1'b1;
                    end
                    if (i_in_data.last_sample) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_emit_adv) begin
                    w_op         = CELL_SHIFT;
                    n_out_valid  = 1'b1;
                    n_out_data   = '{distinct_value:   w_head.value,
                                     occurrence_count: w_head.count,
                                     gap_halves:       w_hi - w_lo,
                                     last_result:      !w_next.valid,
                                     overflow_flag:    r_drop};
                    n_prev_valid = 1'b1;
                    if (!w_next.valid) begin
                        // axis done: row is empty after this shift
                        n_state      = ST_LOAD;
                        n_drop       = 1'b0;
                        n_prev_valid = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_drop       <= 1'b0;
            r_prev_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_drop       <= n_drop;
            r_prev_valid <= n_prev_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (w_emit_adv) begin
            r_prev <= w_head.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a sample equals at most one stored value
    `SUCG_ASSERT_NOW(a_single_match, i_clk, i_rst_n, 1'b1, $onehot0(w_match))
    // the first two cells stay packed to the left and strictly ascending
    `SUCG_ASSERT_NOW(a_row_sorted, i_clk, i_rst_n, w_cell[1].data.valid,
        w_cell[0].data.valid && (w_cell[0].data.value < w_cell[1].data.value))
    // draining never runs on an empty row
    `SUCG_ASSERT_NOW(a_emit_nonempty, i_clk, i_rst_n, r_state == ST_EMIT, w_cell[0].data.valid)
    // a stalled result word stays valid and unchanged
    `SUCG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        r_out_valid && i_out_stall, r_out_valid && $stable(r_out_data))

endmodule

### rtl/sucg_cell.sv
// one insertion cell: holds a distinct value and its count
// depends on sucg_pkg
module sucg_cell import sucg_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_op                  i_op,
    input  logic signed [VALUE_W-1:0] i_sample,
    input  logic                      i_insert,
    input  t_link                     i_left,
    input  t_cell_data                i_right,
    output t_link                     o_link,
    output logic                      o_match
);

    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic [COUNT_W-1:0]        r_count;
    t_cell_data                w_data;
    t_cell_data                n_data;
    logic                      w_less;

    always_comb begin
        w_data  = '{valid: r_valid, value: r_value, count: r_count};
        w_less  = r_valid && (r_value < i_sample);
        o_match = r_valid && (r_value == i_sample);
        o_link  = '{data: w_data, less: w_less};
    end

    always_comb begin
        n_data = w_data;
        unique case (i_op)
            CELL_HOLD: begin
                n_data = w_data;
            end
            CELL_ABSORB: begin
                if (o_match) begin
                    if (r_count != COUNT_MAX) begin
                        n_data.count = r_count + COUNT_W'(1);
                    end
                end else if (i_insert && !w_less) begin
                    // new value lands here when the left side is smaller, else shift right
                    if (i_left.less) begin
                        n_data = '{valid: 1'b1, value: i_sample, count: COUNT_START};
                    end else begin
                        n_data = i_left.data;
                    end
                end
            end
            CELL_SHIFT: begin
                n_data = i_right;
            end
            default: begin
                n_data = w_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_data.value;
        r_count <= n_data.count;
    end

endmodule

### tb/tb_top.sv
// testbench top for sorted_unique_count_gap: feeds coordinate words per axis in bursts,
// predicts the sorted distinct-value histogram and checks every emitted result word
// depends on sucg_pkg and the rtl top level sorted_unique_count_gap
module tb_top;
    import sucg_pkg::*;

    localparam int CAPACITY       = 64;     // distinct values the block can hold
    localparam int STIM_WORDS     = 280;    // random-phase words queued
    localparam int HOLD_AFTER     = 40;     // results taken before the long output hold
    localparam int HOLD_CYCLES    = 400;    // length of the long output hold
    localparam int TAIL_CYCLES    = 2 * CAPACITY;
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no word moving on either side

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // channels
    logic      in_valid  = 1'b0;
    t_in_word  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_data;

    sorted_unique_count_gap #(
        .MAX_POINTS (CAPACITY)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // coordinate words waiting to be offered, filled by the stimulus block
    t_in_word pending_words[$];

    // histogram predictor: its own copy of the sorted row
    logic signed [VALUE_W-1:0] hist_value [CAPACITY];
    logic [COUNT_W-1:0]        hist_count [CAPACITY];
    int                        hist_fill    = 0;
    logic                      hist_dropped = 1'b0;
    t_out_word                 expected_words[$];

    int mismatches = 0;

    // fold one accepted coordinate into the row; on the last one of the axis,
    // queue one expected result per distinct value and start a new axis
    function automatic void tally_word(t_in_word w);
        int        pos;
        int        k;
        int        i;
        t_out_word r;
        pos = 0;
        while (pos < hist_fill && $signed(hist_value[pos]) < $signed(w.sample_value))
            pos++;
        if (pos < hist_fill && hist_value[pos] == w.sample_value) begin
            // repeat of a stored value still counts when the row is full
            if (hist_count[pos] != COUNT_MAX)
                hist_count[pos]++;
        end else if (hist_fill == CAPACITY) begin
            hist_dropped = 1'b1;
        end else begin
            for (k = hist_fill; k > pos; k--) begin
                hist_value[k] = hist_value[k-1];
                hist_count[k] = hist_count[k-1];
            end
            hist_value[pos] = w.sample_value;
            hist_count[pos] = COUNT_START;
            hist_fill++;
        end
        if (w.last_sample) begin
            for (i = 0; i < hist_fill; i++) begin
                r.distinct_value   = hist_value[i];
                r.occurrence_count = hist_count[i];
                // gaps wrap as unsigned 32-bit differences, exact in half-lsb units
                if (hist_fill == 1)
                    r.gap_halves = '0;
                else if (i == 0)
                    r.gap_halves = hist_value[1] - hist_value[0];
                else if (i == hist_fill - 1)
                    r.gap_halves = hist_value[i] - hist_value[i-1];
                else
                    r.gap_halves = hist_value[i+1] - hist_value[i-1];
                r.last_result   = (i == hist_fill - 1);
                r.overflow_flag = hist_dropped;
                expected_words.insert(expected_words.size(), r);
            end
            hist_fill    = 0;
            hist_dropped = 1'b0;
        end
    endfunction

    task automatic queue_word(input logic [VALUE_W-1:0] v, input logic last);
        t_in_word w;
        w.sample_value = v;
        w.last_sample  = last;
        pending_words.insert(pending_words.size(), w);
    endtask

    // short axis: fully random values, a tight cluster for repeats, or extremes
    task automatic queue_short_axis(output int n);
        int                 len;
        int                 flavor;
        int                 i;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] v;
        len    = $urandom_range(1, 12);
        flavor = $urandom_range(0, 2);
        base   = $urandom;
        for (i = 0; i < len; i++) begin
            case (flavor)
                0: v = $urandom;
                1: v = base + $urandom_range(0, 5);
                default: begin
                    case ($urandom_range(0, 4))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7fff_ffff;
                        2: v = '0;
                        3: v = '1;
                        default: v = base;
                    endcase
                end
            endcase
            queue_word(v, i == len - 1);
        end
        n = len;
    endtask

    // fills all cells with distinct values, then offers up to six more distinct ones that
    // must be dropped, with repeats of stored values mixed in
    task automatic queue_full_axis(output int n);
        logic [VALUE_W-1:0] pool[$];
        logic [VALUE_W-1:0] stride;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] t;
        int                 extra;
        int                 i;
        int                 j;
        n      = 0;
        stride = $urandom | 32'd1;     // odd stride keeps every value distinct
        base   = $urandom;
        extra  = $urandom_range(0, 6);
        for (i = 0; i < CAPACITY + extra; i++)
            pool.insert(pool.size(), base + i * stride);
        for (i = CAPACITY - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        for (i = 0; i < CAPACITY + extra; i++) begin
            queue_word(pool[i], 1'b0);
            n++;
            if ($urandom_range(0, 3) == 0) begin
                queue_word(pool[$urandom_range(0, (i < CAPACITY) ? i : CAPACITY - 1)], 1'b0);
                n++;
            end
        end
        queue_word(pool[$urandom_range(0, CAPACITY + extra - 1)], 1'b1);
        n++;
    endtask

    // one value repeated past the point where its count saturates
    task automatic queue_saturating_axis(output int n);
        logic [VALUE_W-1:0] v;
        int                 reps;
        int                 i;
        n    = 0;
        v    = $urandom;
        reps = $urandom_range(126, 132);
        for (i = 0; i < reps; i++) begin
            queue_word(v, 1'b0);
            n++;
            if ($urandom_range(0, 15) == 0) begin
                queue_word($urandom, 1'b0);
                n++;
            end
        end
        queue_word(v, 1'b1);
        n++;
    endtask

    // stimulus, reset and end of run
    initial begin
        int queued;
        int n;
        queued = 0;

        // single sample axis: count 2, gap 0
        queue_word(32'sd0, 1'b1);
        // both extremes: widest possible gap on each side
        queue_word(32'h8000_0000, 1'b0);
        queue_word(32'h7fff_ffff, 1'b1);
        // out of order with repeats, inner gap spans the neighbors
        queue_word(32'h7fff_ffff, 1'b0);
        queue_word(32'h8000_0000, 1'b0);
        queue_word(32'h7fff_ffff, 1'b0);
        queue_word(32'hffff_ffff, 1'b0);
        queue_word(32'h0000_0001, 1'b1);
        // alternating bit patterns, last word a repeat
        queue_word(32'h5555_5555, 1'b0);
        queue_word(32'haaaa_aaaa, 1'b0);
        queue_word(32'h5555_5555, 1'b1);
        // one distinct value seen several times
        queue_word(32'h0001_0000, 1'b0);
        queue_word(32'h0001_0000, 1'b0);
        queue_word(32'h0001_0000, 1'b1);
        // neighbors one lsb apart across zero
        queue_word(32'h0000_0000, 1'b0);
        queue_word(32'hffff_ffff, 1'b0);
        queue_word(32'h0000_0001, 1'b1);

        // capacity and saturation first so the long output hold lands on a full drain
        queue_full_axis(n);
        queued += n;
        queue_saturating_axis(n);
        queued += n;
        while (queued < STIM_WORDS) begin
            if ($urandom_range(0, 11) == 0)
                queue_full_axis(n);
            else
                queue_short_axis(n);
            queued += n;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        // catch anything emitted beyond the prediction
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** sorted_unique_count_gap: PASSED **");
        else
            $display("** sorted_unique_count_gap: FAILED **");
        $finish;
    end

    // sender: bursts of random length separated by random gaps, some with none;
    // a word stays put until it is taken
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!in_valid || !in_stall) begin
            // slot is free after this edge
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                in_valid <= 1'b1;
                in_data  <= pending_words.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall modes that change at random, plus one long hold
    // once the first results have gone by so the row fills and the input backs up
    t_stall_mode stall_mode    = STALL_NONE;
    int          mode_left     = 0;
    int          stall_phase   = 0;
    int          hold_left     = 0;
    logic        hold_done     = 1'b0;
    int          results_taken = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall     <= 1'b0;
            stall_mode    = STALL_NONE;
            mode_left     = 0;
            stall_phase   = 0;
            hold_left     = 0;
            hold_done     = 1'b0;
            results_taken = 0;
        end else begin
            if (out_valid && !out_stall)
                results_taken++;
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!hold_done && results_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 2));
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                stall_phase++;
                case (stall_mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
                    default:      out_stall <= (stall_phase % 5 == 1) || (stall_phase % 5 == 2);
                endcase
            end
        end
    end

    // monitor: predicts from accepted input words, checks accepted result words
    // against the oldest expectation, and runs the watchdog
    int idle_cycles = 0;

    always @(posedge clk) begin
        t_out_word want;
        if (rst_n) begin
            // input first, so a same-edge result always finds its prediction
            if (in_valid && !in_stall)
                tally_word(in_data);
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word with none expected: distinct_value %0d",
                           out_data.distinct_value);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (out_data.distinct_value !== want.distinct_value) begin
                        $error("distinct_value: expected %0d, got %0d",
                               want.distinct_value, out_data.distinct_value);
                        mismatches++;
                    end
                    if (out_data.occurrence_count !== want.occurrence_count) begin
                        $error("occurrence_count: expected %0d, got %0d",
                               want.occurrence_count, out_data.occurrence_count);
                        mismatches++;
                    end
                    if (out_data.gap_halves !== want.gap_halves) begin
                        $error("gap_halves: expected %0d, got %0d",
                               want.gap_halves, out_data.gap_halves);
                        mismatches++;
                    end
                    if (out_data.last_result !== want.last_result) begin
                        $error("last_result: expected %0b, got %0b",
                               want.last_result, out_data.last_result);
                        mismatches++;
                    end
                    if (out_data.overflow_flag !== want.overflow_flag) begin
                        $error("overflow_flag: expected %0b, got %0b",
                               want.overflow_flag, out_data.overflow_flag);
                        mismatches++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** sorted_unique_count_gap: FAILED **");
                $finish;
            end
        end
    end

endmodule

### filelist.f
+incdir+rtl
rtl/sucg_pkg.sv
rtl/sucg_cell.sv
rtl/sorted_unique_count_gap.sv
tb/tb_top.sv
